// File: sv/cfb_pkg.sv
`default_nettype none

package cfb_pkg;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [ByteW-1:0] LeadByte = 8'h55;

  // Positions of the header bytes within a frame.
  localparam logic [IdxW-1:0] IdxLead  = 3'd0;
  localparam logic [IdxW-1:0] IdxCla   = 3'd1;
  localparam logic [IdxW-1:0] IdxIns   = 3'd2;
  localparam logic [IdxW-1:0] IdxP1    = 3'd3;
  localparam logic [IdxW-1:0] IdxP2    = 3'd4;
  localparam logic [IdxW-1:0] IdxLenHi = 3'd5;
  localparam logic [IdxW-1:0] IdxLenLo = 3'd6;
  localparam logic [IdxW-1:0] IdxCheck = 3'd7;
  localparam logic [IdxW-1:0] IdxDataCheck = 3'd1;

  typedef enum logic {
    CMD_HEADER = 1'b0,
    CMD_DATA   = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                kind;
    logic                close;
    logic [ByteW-1:0]    check;
    logic [InDataW-1:0]  payload;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

// File: sv/command_frame_builder_xor_lrc.sv
// Command frame builder with an inverted XOR check byte.
// Input stream (s_axis_*): tuser selects a header (0) or a data byte (1).
// A header transfer expands to seven bytes: 0x55, class, instruction, P1, P2,
// length high and length low, and opens a frame of the given length. Each data
// transfer of an open frame is passed on as one byte; data with no open frame
// is discarded. The check byte, the inverse of the XOR of every byte from
// class to the last data byte, follows the last data byte (or the header when
// the length is zero) and is marked by m_axis_tlast.
// A front stage tracks the frame and classifies transfers into a queue of
// FifoDepth entries; a back stage serialises each entry into a registered
// output byte. An accepted transfer is written into the queue and then loaded
// into the output register. Data bytes stream at one per cycle while the receiver
// is ready; a header's seven or eight bytes and a closing data byte with its check
// byte leave one at a time through the single-byte output register.
// When the receiver stalls the output holds and the queue absorbs input until
// full, after which s_axis_tready drops. Reset empties the queue and the
// output register and closes any open frame.
`default_nettype none

module command_frame_builder_xor_lrc #(
  parameter int unsigned FifoDepth = cfb_pkg::FifoDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] class_byte, [15:8] instruction_byte, [23:16] param_one,
  // [31:24] param_two, [47:32] data_length, [55:48] data_byte
  input  wire logic [55:0] s_axis_tdata,
  // [0] command
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);

  logic                  accept;
  logic                  push;
  logic                  pop;
  cfb_pkg::entry_t       entry;
  cfb_pkg::entry_t       head;
  cfb_pkg::fifo_status_t status;

  assign s_axis_tready = !status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cfb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .user_i   (s_axis_tuser),
    .data_i   (s_axis_tdata),
    .push_o   (push),
    .entry_o  (entry)
  );

  cfb_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  cfb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .status_i  (status),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: sv/cfb_front.sv
`default_nettype none

module cfb_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [0:0]                    user_i,
  input  wire logic [cfb_pkg::InDataW-1:0]   data_i,
  output logic                               push_o,
  output cfb_pkg::entry_t                    entry_o
);

  logic [cfb_pkg::LenW-1:0]  rem_q, rem_d;
  logic [cfb_pkg::ByteW-1:0] acc_q, acc_d;
  logic                      open_q, open_d;

  cfb_pkg::cmd_e             cmd;
  logic [cfb_pkg::LenW-1:0]  len;
  logic [cfb_pkg::ByteW-1:0] hdr_xor;
  logic [cfb_pkg::LenW-1:0]  rem_dec;
  logic [cfb_pkg::ByteW-1:0] acc_data;

  assign cmd      = cfb_pkg::cmd_e'(user_i[0]);
  assign len      = data_i[47:32];
  assign hdr_xor  = data_i[7:0] ^ data_i[15:8] ^ data_i[23:16] ^ data_i[31:24]
                    ^ len[15:8] ^ len[7:0];
  assign rem_dec  = rem_q - 16'd1;
  assign acc_data = acc_q ^ data_i[55:48];

  always_comb begin
    rem_d   = rem_q;
    acc_d   = acc_q;
    open_d  = open_q;
    push_o  = 1'b0;
    entry_o.kind    = cmd;
    entry_o.payload = data_i;
    entry_o.close   = 1'b0;
    entry_o.check   = ~hdr_xor;
    if (accept_i) begin
      unique case (cmd)
        cfb_pkg::CMD_HEADER: begin
          // A header always restarts the frame, dropping any open one.
          push_o        = 1'b1;
          rem_d         = len;
          acc_d         = hdr_xor;
          open_d        = (len != '0);
          entry_o.close = (len == '0);
          entry_o.check = ~hdr_xor;
        end
        cfb_pkg::CMD_DATA: begin
          if (open_q) begin
            push_o        = 1'b1;
            rem_d         = rem_dec;
            acc_d         = acc_data;
            open_d        = (rem_dec != '0);
            entry_o.close = (rem_dec == '0);
            entry_o.check = ~acc_data;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      acc_q  <= '0;
      open_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      acc_q  <= acc_d;
      open_q <= open_d;
    end
  end

  a_open_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == (rem_q != '0))
    else $error("frame open flag disagrees with remaining byte count");

  a_data_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && cmd == cfb_pkg::CMD_DATA && !open_q) |-> !push_o)
    else $error("data byte without open frame was queued");

endmodule

`default_nettype wire

// File: sv/cfb_fifo.sv
`default_nettype none

module cfb_fifo #(
  parameter int unsigned Depth = cfb_pkg::FifoDepthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire cfb_pkg::entry_t       entry_i,
  input  wire logic                  pop_i,
  output cfb_pkg::entry_t            head_o,
  output cfb_pkg::fifo_status_t      status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cfb_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

// File: sv/cfb_back.sv
`default_nettype none

module cfb_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cfb_pkg::entry_t             head_i,
  input  wire cfb_pkg::fifo_status_t       status_i,
  output logic                             pop_o,
  output logic                             m_valid_o,
  input  wire logic                        m_ready_i,
  output logic [cfb_pkg::ByteW-1:0]        m_data_o,
  output logic                             m_last_o
);

  logic [cfb_pkg::IdxW-1:0]  idx_q, idx_d;
  logic                      valid_q, valid_d;
  logic [cfb_pkg::ByteW-1:0] byte_q, byte_d;
  logic                      last_q, last_d;

  logic                      load;
  logic [cfb_pkg::IdxW-1:0]  last_idx;
  logic [cfb_pkg::ByteW-1:0] sel_byte;
  logic                      at_end;

  // The output register is refilled whenever it is empty or being taken.
  assign load = !valid_q || m_ready_i;

  always_comb begin
    sel_byte = head_i.check;
    unique case (head_i.kind)
      cfb_pkg::CMD_HEADER: begin
        last_idx = head_i.close ? cfb_pkg::IdxCheck : cfb_pkg::IdxLenLo;
        unique case (idx_q)
          cfb_pkg::IdxLead:  sel_byte = cfb_pkg::LeadByte;
          cfb_pkg::IdxCla:   sel_byte = head_i.payload[7:0];
          cfb_pkg::IdxIns:   sel_byte = head_i.payload[15:8];
          cfb_pkg::IdxP1:    sel_byte = head_i.payload[23:16];
          cfb_pkg::IdxP2:    sel_byte = head_i.payload[31:24];
          cfb_pkg::IdxLenHi: sel_byte = head_i.payload[47:40];
          cfb_pkg::IdxLenLo: sel_byte = head_i.payload[39:32];
          cfb_pkg::IdxCheck: sel_byte = head_i.check;
          default:           sel_byte = head_i.check;
        endcase
      end
      cfb_pkg::CMD_DATA: begin
        last_idx = head_i.close ? cfb_pkg::IdxDataCheck : '0;
        sel_byte = (idx_q == '0) ? head_i.payload[55:48] : head_i.check;
      end
      default: last_idx = '0;
    endcase
  end

  assign at_end = (idx_q == last_idx);
  assign pop_o  = load && !status_i.empty && at_end;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (load) begin
      valid_d = !status_i.empty;
      if (!status_i.empty) begin
        byte_d = sel_byte;
        last_d = head_i.close && at_end;
        idx_d  = at_end ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = byte_q;
  assign m_last_o  = last_q;

  a_mid_entry_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> !status_i.empty)
    else $error("byte counter mid-entry but queue is empty");

  a_pop_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (idx_d == '0))
    else $error("entry released before its last byte");

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 20;

  // One stimulus row. When typed is set, n_exp and exp hold the expected bytes
  // as {frame_end, out_byte}, first byte at index 0.
  typedef struct packed {
    cfb_pkg::cmd_e    kind;
    logic [7:0]       cla;
    logic [7:0]       ins;
    logic [7:0]       p1;
    logic [7:0]       p2;
    logic [15:0]      len;
    logic [7:0]       dat;
    logic             typed;
    logic [3:0]       n_exp;
    logic [0:7][8:0]  exp;
  } item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  item_t       items_q[$];
  logic [8:0]  frame_bytes_q[$];
  int unsigned mismatches;
  int unsigned cycles;

  // Predictor state: data bytes still owed, running XOR, frame open.
  logic [15:0] pend_left;
  logic [7:0]  run_xor;
  logic        in_frame;

  command_frame_builder_xor_lrc u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic item_t row(input cfb_pkg::cmd_e kind, input logic [7:0] cla,
                                input logic [7:0] ins,
                                input logic [7:0] p1, input logic [7:0] p2,
                                input logic [15:0] len, input logic [7:0] dat,
                                input logic typed, input logic [3:0] n_exp,
                                input logic [0:7][8:0] exp);
    item_t it;
    it.kind  = kind;
    it.cla   = cla;
    it.ins   = ins;
    it.p1    = p1;
    it.p2    = p2;
    it.len   = len;
    it.dat   = dat;
    it.typed = typed;
    it.n_exp = n_exp;
    it.exp   = exp;
    return it;
  endfunction

  function automatic item_t rand_item(input cfb_pkg::cmd_e kind, input logic [15:0] len);
    return row(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
               8'($urandom_range(0, 255)), 1'b0, 4'd0, '0);
  endfunction

  // Works out the bytes that one accepted transfer produces and advances the
  // frame state.
  function automatic int predict_frame(input item_t it, output logic [0:7][8:0] bytes);
    int n;
    logic [7:0] lrc;
    n = 0;
    bytes = '0;
    if (it.kind == cfb_pkg::CMD_HEADER) begin
      bytes[0] = {1'b0, cfb_pkg::LeadByte};
      bytes[1] = {1'b0, it.cla};
      bytes[2] = {1'b0, it.ins};
      bytes[3] = {1'b0, it.p1};
      bytes[4] = {1'b0, it.p2};
      bytes[5] = {1'b0, it.len[15:8]};
      bytes[6] = {1'b0, it.len[7:0]};
      n = 7;
      lrc = it.cla ^ it.ins ^ it.p1 ^ it.p2 ^ it.len[15:8] ^ it.len[7:0];
      run_xor = lrc;
      pend_left = it.len;
      if (it.len == 16'd0) begin
        bytes[7] = {1'b1, ~lrc};
        n = 8;
        in_frame = 1'b0;
      end else begin
        in_frame = 1'b1;
      end
    end else if (in_frame) begin
      bytes[0] = {1'b0, it.dat};
      n = 1;
      run_xor = run_xor ^ it.dat;
      pend_left = pend_left - 16'd1;
      if (pend_left == 16'd0) begin
        bytes[1] = {1'b1, ~run_xor};
        n = 2;
        in_frame = 1'b0;
      end
    end
    return n;
  endfunction

  // Mostly complete frames with short payloads; some frames are cut short by
  // a new header, and stray data bytes arrive between frames.
  task automatic build_random_items();
    int unsigned counted;
    int unsigned pick;
    int unsigned k;
    logic [15:0] len;
    logic        open;
    counted = 0;
    open = 1'b0;
    while (counted < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 40))
                                          : 16'($urandom_range(0, 6));
        items_q.push_back(rand_item(cfb_pkg::CMD_HEADER, len));
        for (k = 0; k < len; k++) begin
          items_q.push_back(rand_item(cfb_pkg::CMD_DATA, 16'($urandom)));
        end
        counted += len + 1;
        open = 1'b0;
      end else if (pick < 85) begin
        len = 16'($urandom_range(1, 65535));
        k = $urandom_range(0, 5);
        items_q.push_back(rand_item(cfb_pkg::CMD_HEADER, len));
        for (int j = 0; j < k; j++) begin
          items_q.push_back(rand_item(cfb_pkg::CMD_DATA, 16'($urandom)));
        end
        counted += k + 1;
        open = (k < len);
      end else begin
        k = $urandom_range(1, 3);
        for (int j = 0; j < k; j++) begin
          items_q.push_back(rand_item(cfb_pkg::CMD_DATA, 16'($urandom)));
        end
        if (open) counted += k;
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    logic [8:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frame_bytes_q.size() == 0) begin
        flag_mismatch("transfer with nothing outstanding", 0, m_axis_tdata);
      end else begin
        want = frame_bytes_q.pop_front();
        if (m_axis_tdata !== want[7:0]) flag_mismatch("out_byte", want[7:0], m_axis_tdata);
        if (m_axis_tlast !== want[8]) flag_mismatch("frame_end", want[8], m_axis_tlast);
      end
    end
  end

  // Receiver: random waits per transfer, calm stretches, and one long hold-off
  // so that the queue inside the block fills and the input stalls.
  initial begin : sink
    int unsigned wait_n;
    int unsigned taken;
    bit          calm;
    bit          held;
    taken = 0;
    calm = 1'b0;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      wait_n = calm ? 0 : $urandom_range(0, 4);
      if (!held && taken >= 120) begin
        held = 1'b1;
        wait_n = HoldCycles;
      end
      if (wait_n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  initial begin : source
    int unsigned      gap;
    int               n;
    bit               calm;
    logic [0:7][8:0]  got;
    item_t            it;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    mismatches = 0;
    cycles = 0;
    pend_left = '0;
    run_xor = '0;
    in_frame = 1'b0;
    calm = 1'b0;

    // Directed rows: stray data after reset, length-zero frames at the byte
    // extremes, a one-byte frame, data after a closed frame, a maximum length
    // frame dropped by a restart, and a restart of a frame after its first data byte.
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00,
                          1'b1, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
                          1'b1, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_HEADER, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'hFF,
                          1'b1, 4'd8, {9'h055, 9'h000, 9'h000, 9'h000, 9'h000,
                                       9'h000, 9'h000, 9'h1FF}));
    items_q.push_back(row(cfb_pkg::CMD_HEADER, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 8'h00,
                          1'b1, 4'd8, {9'h055, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
                                       9'h000, 9'h000, 9'h1FF}));
    items_q.push_back(row(cfb_pkg::CMD_HEADER, 8'hA5, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00,
                          1'b1, 4'd8, {9'h055, 9'h0A5, 9'h000, 9'h000, 9'h000,
                                       9'h000, 9'h000, 9'h15A}));
    items_q.push_back(row(cfb_pkg::CMD_HEADER, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0001, 8'h00,
                          1'b1, 4'd7, {9'h055, 9'h000, 9'h000, 9'h000, 9'h000,
                                       9'h000, 9'h001, 9'h000}));
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'h00,
                          1'b1, 4'd2, {9'h000, 9'h1FE, 9'h000, 9'h000, 9'h000,
                                       9'h000, 9'h000, 9'h000}));
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h3C,
                          1'b1, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_HEADER, 8'h80, 8'hA4, 8'h04, 8'h00, 16'h0003, 8'h11,
                          1'b0, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h11,
                          1'b0, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h22,
                          1'b0, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'hFF,
                          1'b0, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_HEADER, 8'h00, 8'hC0, 8'h00, 8'h00, 16'hFFFF, 8'h00,
                          1'b1, 4'd7, {9'h055, 9'h000, 9'h0C0, 9'h000, 9'h000,
                                       9'h0FF, 9'h0FF, 9'h000}));
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h7E,
                          1'b0, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h01,
                          1'b0, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_HEADER, 8'h12, 8'h34, 8'h56, 8'h78, 16'h0002, 8'h00,
                          1'b0, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'hAA,
                          1'b0, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h55,
                          1'b0, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_HEADER, 8'h5A, 8'hA5, 8'hC3, 8'h3C, 16'h0100, 8'h00,
                          1'b0, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h5A,
                          1'b0, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_HEADER, 8'h01, 8'h02, 8'h03, 8'h04, 16'h0001, 8'h00,
                          1'b0, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'hFF,
                          1'b0, 4'd0, '0));
    items_q.push_back(row(cfb_pkg::CMD_DATA,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h80,
                          1'b0, 4'd0, '0));
    build_random_items();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < items_q.size(); i++) begin
      it = items_q[i];
      if (i % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {it.dat, it.len, it.p2, it.p1, it.ins, it.cla};
      s_axis_tuser <= it.kind;
      do @(posedge clk_i); while (!s_axis_tready);
      n = predict_frame(it, got);
      if (it.typed) begin
        n = it.n_exp;
        got = it.exp;
      end
      for (int k = 0; k < n; k++) frame_bytes_q.push_back(got[k]);
    end
    s_axis_tvalid <= 1'b0;

    while (frame_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && frame_bytes_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
